// File: src/zcwf_pkg.sv
// Shared types, codes and helper functions for the zigzag coverage planner.
package zcwf_pkg;

  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int COORD_BITS_DEF    = 8;
  localparam int LIM_W             = 13;
  localparam int CLEAN_W           = 16;
  localparam logic [LIM_W-1:0] CNT_MAX  = '1;
  localparam logic [LIM_W-1:0] LIM_RST  = 13'd256;

  typedef enum logic [2:0] {
    DIR_UP    = 3'd0,
    DIR_DOWN  = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_RIGHT = 3'd3,
    DIR_NONE  = 3'd4
  } dir_t;

  typedef enum logic [1:0] {
    MODE_SWEEP = 2'd0,
    MODE_SHIFT = 2'd1,
    MODE_WALL  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_t;

  typedef enum logic {
    CFG_STAG_LIMIT = 1'b0,
    CFG_WALL_LIMIT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic wr;
    logic start;
  } hist_ctl_t;

  // Two-bit heading codes: up 0, down 1, left 2, right 3.
  function automatic logic [1:0] rot_cw(input logic [1:0] h);
    logic [1:0] r;
    case (h)
      2'd0:    r = 2'd3;
      2'd1:    r = 2'd2;
      2'd2:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] rot_ccw(input logic [1:0] h);
    logic [1:0] r;
    case (h)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd3;
      2'd2:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] flip_dir(input logic [1:0] h);
    return {h[1], ~h[0]};
  endfunction

  // Four-pass neighbor preference: fresh and unvisited, unvisited,
  // uncleaned, then anything free.
  function automatic dir_t fallback_dir(input logic [3:0] freem,
                                        input logic [3:0] cleanm,
                                        input logic [3:0] recent);
    dir_t res;
    logic found;
    logic ok;
    res   = DIR_NONE;
    found = 1'b0;
    ok    = 1'b0;
    for (int p = 0; p < 4; p++) begin
      for (int d = 0; d < 4; d++) begin
        case (p)
          0:       ok = !cleanm[d] && !recent[d];
          1:       ok = !recent[d];
          2:       ok = !cleanm[d];
          default: ok = 1'b1;
        endcase
        if (!found && freem[d] && ok) begin
          res   = dir_t'(3'(d));
          found = 1'b1;
        end
      end
    end
    return res;
  endfunction

endpackage

// File: src/zigzag_coverage_wall_follow_planner.sv
// Top level of the zigzag coverage planner with wall following.
// A request is taken only while idle; the history scan then reads one
//   entry per cycle, and the decision is registered as the scan completes
//   and held until the result is taken; only then is a new request taken.
// Reset (rst_n low, synchronous): mode sweep, sweep right, shift down,
//   counters and history fill cleared, both limits back to 256.
module zigzag_coverage_wall_follow_planner import zcwf_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Move request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_pos_x,
  input  logic [COORD_BITS-1:0] in_pos_y,
  input  logic [3:0]            in_free_mask,
  input  logic [3:0]            in_cleaned_mask,
  input  logic [3:0]            in_rejoin_left_mask,
  input  logic [3:0]            in_rejoin_right_mask,
  input  logic [CLEAN_W-1:0]    in_cleaned_count,
  // Move result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_move_dir,
  output logic [1:0]            out_mode_after,
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [LIM_W-1:0]      cfg_data
);

  state_t                state_r, state_nxt;
  logic [LIM_W-1:0]      stag_limit_r, wall_limit_r;
  logic [COORD_BITS-1:0] pos_x_r, pos_y_r;
  logic [3:0]            free_r, clean_r, rejl_r, rejr_r;
  logic [CLEAN_W-1:0]    count_r;
  logic [2:0]            move_r;
  logic [1:0]            mode_out_r;
  logic                  accept, done;
  logic [3:0]            recent;
  hist_ctl_t             hctl;
  dir_t                  plan_move;
  mode_t                 plan_mode;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Sequencer: take a request, scan history, decide, present the result.
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers; the user must write only while idle, unchecked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stag_limit_r <= LIM_RST;
      wall_limit_r <= LIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STAG_LIMIT: stag_limit_r <= cfg_data;
        CFG_WALL_LIMIT: wall_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the request for the whole transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      free_r  <= in_free_mask;
      clean_r <= in_cleaned_mask;
      rejl_r  <= in_rejoin_left_mask;
      rejr_r  <= in_rejoin_right_mask;
      count_r <= in_cleaned_count;
    end
  end

  // Record the visit at accept, then scan from the next cycle.
  assign hctl.wr    = accept;
  assign hctl.start = accept;

  zcwf_hist #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .COORD_BITS    (COORD_BITS)
  ) u_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (hctl),
    .wr_x   (in_pos_x),
    .wr_y   (in_pos_y),
    .cur_x  (pos_x_r),
    .cur_y  (pos_y_r),
    .recent (recent),
    .done   (done)
  );

  zcwf_plan #(
    .COORD_BITS (COORD_BITS)
  ) u_plan (
    .clk               (clk),
    .rst_n             (rst_n),
    .upd               (done),
    .stag_limit        (stag_limit_r),
    .wall_limit        (wall_limit_r),
    .pos_y             (pos_y_r),
    .free_mask         (free_r),
    .cleaned_mask      (clean_r),
    .rejoin_left_mask  (rejl_r),
    .rejoin_right_mask (rejr_r),
    .cleaned_count     (count_r),
    .recent            (recent),
    .move_dir          (plan_move),
    .mode_after        (plan_mode)
  );

  // Output register: load the decision as the scan completes.
  always_ff @(posedge clk) begin
    if (done) begin
      move_r     <= plan_move;
      mode_out_r <= plan_mode;
    end
  end

  assign out_move_dir   = move_r;
  assign out_mode_after = mode_out_r;

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_SCAN) else $error("accept did not start scan");
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> state_r == ST_SCAN) else $error("scan done outside scan state");
  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(done)) else $error("result without decision");

endmodule

// File: src/zcwf_hist.sv
// Recent-cell history memory with an iterative neighbor compare unit.
module zcwf_hist import zcwf_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hist_ctl_t             ctl,
  input  logic [COORD_BITS-1:0] wr_x,
  input  logic [COORD_BITS-1:0] wr_y,
  input  logic [COORD_BITS-1:0] cur_x,
  input  logic [COORD_BITS-1:0] cur_y,
  output logic [3:0]            recent,
  output logic                  done
);

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(HISTORY_DEPTH);

  logic [COORD_BITS-1:0] mem_x [HISTORY_DEPTH];
  logic [COORD_BITS-1:0] mem_y [HISTORY_DEPTH];

  logic [IDX_W-1:0]      wptr_r, idx_r;
  logic [CNT_W-1:0]      fill_r;
  logic                  busy_r, rdv_r, last_r, done_r;
  logic [COORD_BITS-1:0] rd_x_r, rd_y_r;
  logic [3:0]            recent_r, match;
  logic [COORD_BITS-1:0] nx [4];
  logic [COORD_BITS-1:0] ny [4];

  // Write the new cell; read one entry per cycle while scanning.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem_x[wptr_r] <= wr_x;
      mem_y[wptr_r] <= wr_y;
    end
    if (busy_r) begin
      rd_x_r <= mem_x[idx_r];
      rd_y_r <= mem_y[idx_r];
    end
  end

  always_comb begin
    nx[0] = cur_x;                       ny[0] = cur_y - 1'b1;
    nx[1] = cur_x;                       ny[1] = cur_y + 1'b1;
    nx[2] = cur_x - 1'b1;                ny[2] = cur_y;
    nx[3] = cur_x + 1'b1;                ny[3] = cur_y;
    for (int d = 0; d < 4; d++) begin
      match[d] = (rd_x_r == nx[d]) && (rd_y_r == ny[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r   <= '0;
      fill_r   <= '0;
      busy_r   <= 1'b0;
      idx_r    <= '0;
      rdv_r    <= 1'b0;
      last_r   <= 1'b0;
      done_r   <= 1'b0;
      recent_r <= '0;
    end else begin
      if (ctl.wr) begin
        wptr_r <= (wptr_r == IDX_LAST) ? '0 : IDX_W'(wptr_r + 1'b1);
        if (fill_r != FILL_MAX) begin
          fill_r <= CNT_W'(fill_r + 1'b1);
        end
      end
      if (ctl.start) begin
        busy_r   <= 1'b1;
        idx_r    <= '0;
        recent_r <= '0;
      end else begin
        if (busy_r) begin
          idx_r <= IDX_W'(idx_r + 1'b1);
          if (idx_r == IDX_LAST) begin
            busy_r <= 1'b0;
          end
        end
        if (rdv_r) begin
          recent_r <= recent_r | match;
        end
      end
      rdv_r  <= busy_r && (CNT_W'(idx_r) < fill_r);
      last_r <= busy_r && (idx_r == IDX_LAST);
      done_r <= last_r;
    end
  end

  assign recent = recent_r;
  assign done   = done_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX) else $error("history fill beyond depth");
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    last_r |=> done_r) else $error("scan end not flagged");
  a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !ctl.wr) else $error("history written during scan");

endmodule

// File: src/zcwf_plan.sv
// Planner state and the sweep, shift and wall-follow decision.
module zcwf_plan import zcwf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  upd,
  input  logic [LIM_W-1:0]      stag_limit,
  input  logic [LIM_W-1:0]      wall_limit,
  input  logic [COORD_BITS-1:0] pos_y,
  input  logic [3:0]            free_mask,
  input  logic [3:0]            cleaned_mask,
  input  logic [3:0]            rejoin_left_mask,
  input  logic [3:0]            rejoin_right_mask,
  input  logic [CLEAN_W-1:0]    cleaned_count,
  input  logic [3:0]            recent,
  output dir_t                  move_dir,
  output mode_t                 mode_after
);

  mode_t                 mode_r, mode_nxt;
  logic                  sweep_dir_r, sweep_dir_nxt, shift_dir_r, shift_dir_nxt;
  logic [1:0]            heading_r, heading_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic                  resume_r, resume_nxt;
  logic [LIM_W-1:0]      follow_r, follow_nxt, idle_r, idle_nxt;
  logic [CLEAN_W-1:0]    last_cleaned_r;
  logic                  last_valid_r;

  logic                  progress, stall, sweep_ok, shift1_ok, shift2_ok, shift_phase;
  logic [1:0]            h_eff, wmove;
  logic                  resume_eff, wfound;
  logic [COORD_BITS-1:0] row_eff, ny;
  logic [LIM_W-1:0]      cnt_base;
  logic [LIM_W:0]        n;
  logic [1:0]            cand [4];
  logic [3:0]            rej;
  dir_t                  move;

  always_comb begin
    progress = !last_valid_r || (cleaned_count > last_cleaned_r);
    if (progress) begin
      idle_nxt = '0;
    end else if (idle_r != CNT_MAX) begin
      idle_nxt = LIM_W'(idle_r + 1'b1);
    end else begin
      idle_nxt = idle_r;
    end
    stall = idle_nxt >= stag_limit;

    sweep_ok    = !stall && free_mask[{1'b1, sweep_dir_r}];
    shift1_ok   = !stall && free_mask[{1'b0, shift_dir_r}];
    shift2_ok   = !stall && free_mask[{1'b0, ~shift_dir_r}];
    shift_phase = ((mode_r == MODE_SWEEP) && !sweep_ok) || (mode_r == MODE_SHIFT);

    // Entering wall follow from the shift phase seeds its context.
    h_eff      = shift_phase ? {1'b1, sweep_dir_r} : heading_r;
    row_eff    = shift_phase ? pos_y : row_r;
    resume_eff = shift_phase ? sweep_dir_r : resume_r;
    cnt_base   = shift_phase ? '0 : follow_r;
    n          = {1'b0, cnt_base} + 1'b1;

    // Right-hand rule: right turn, straight, left turn, back.
    cand[0] = rot_cw(h_eff);
    cand[1] = h_eff;
    cand[2] = rot_ccw(h_eff);
    cand[3] = flip_dir(h_eff);
    wmove   = cand[3];
    wfound  = 1'b0;
    for (int i = 3; i >= 0; i--) begin
      if (free_mask[cand[i]]) begin
        wmove  = cand[i];
        wfound = 1'b1;
      end
    end
    case (wmove)
      2'd0:    ny = pos_y - 1'b1;
      2'd1:    ny = pos_y + 1'b1;
      default: ny = pos_y;
    endcase
    rej = resume_eff ? rejoin_right_mask : rejoin_left_mask;

    mode_nxt      = mode_r;
    sweep_dir_nxt = sweep_dir_r;
    shift_dir_nxt = shift_dir_r;
    heading_nxt   = heading_r;
    row_nxt       = row_r;
    resume_nxt    = resume_r;
    follow_nxt    = follow_r;
    move          = DIR_NONE;

    if ((mode_r == MODE_SWEEP) && sweep_ok) begin
      move = dir_t'({1'b0, 1'b1, sweep_dir_r});
    end else if (shift_phase && shift1_ok) begin
      sweep_dir_nxt = ~sweep_dir_r;
      mode_nxt      = MODE_SWEEP;
      move          = dir_t'({2'b00, shift_dir_r});
    end else if (shift_phase && shift2_ok) begin
      shift_dir_nxt = ~shift_dir_r;
      sweep_dir_nxt = ~sweep_dir_r;
      mode_nxt      = MODE_SWEEP;
      move          = dir_t'({2'b00, ~shift_dir_r});
    end else begin
      row_nxt     = row_eff;
      resume_nxt  = resume_eff;
      heading_nxt = h_eff;
      follow_nxt  = (n > {1'b0, CNT_MAX}) ? CNT_MAX : n[LIM_W-1:0];
      mode_nxt    = MODE_WALL;
      if ((n > {1'b0, wall_limit}) || !wfound) begin
        mode_nxt = MODE_SWEEP;
        move     = fallback_dir(free_mask, cleaned_mask, recent);
      end else begin
        move        = dir_t'({1'b0, wmove});
        heading_nxt = wmove;
        if ((ny == row_eff) && rej[wmove]) begin
          mode_nxt      = MODE_SWEEP;
          sweep_dir_nxt = resume_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_SWEEP;
      sweep_dir_r    <= 1'b1;
      shift_dir_r    <= 1'b1;
      follow_r       <= '0;
      idle_r         <= '0;
      last_cleaned_r <= '0;
      last_valid_r   <= 1'b0;
    end else if (upd) begin
      mode_r         <= mode_nxt;
      sweep_dir_r    <= sweep_dir_nxt;
      shift_dir_r    <= shift_dir_nxt;
      follow_r       <= follow_nxt;
      idle_r         <= idle_nxt;
      last_cleaned_r <= cleaned_count;
      last_valid_r   <= 1'b1;
    end
  end

  // Written on entry to wall follow before any read.
  always_ff @(posedge clk) begin
    if (upd) begin
      heading_r <= heading_nxt;
      row_r     <= row_nxt;
      resume_r  <= resume_nxt;
    end
  end

  assign move_dir   = move;
  assign mode_after = mode_nxt;

endmodule

// File: sim/tb_top.sv
// Testbench for the zigzag coverage planner: move scoreboard, request drivers and checks.
`timescale 1ns / 100ps

module tb_top import zcwf_pkg::*;;

  localparam int TRAIL_DEPTH = HISTORY_DEPTH_DEF;

  typedef logic [COORD_BITS_DEF-1:0] coord_t;

  typedef struct {
    coord_t             x;
    coord_t             y;
    logic [3:0]         free_m;
    logic [3:0]         clean_m;
    logic [3:0]         rej_l;
    logic [3:0]         rej_r;
    logic [CLEAN_W-1:0] count;
  } move_req_t;

  typedef struct {
    dir_t  dir;
    mode_t mode;
  } move_res_t;

  class move_board;
    logic [LIM_W-1:0]   stag_limit;
    logic [LIM_W-1:0]   wall_limit;
    mode_t              mode;
    bit                 sweep_right;
    bit                 shift_down;
    dir_t               heading;
    coord_t             sweep_row;
    bit                 resume_right;
    int unsigned        follow_count;
    int unsigned        idle_count;
    logic [CLEAN_W-1:0] last_count;
    bit                 seen_count;
    coord_t             trail_x[TRAIL_DEPTH];
    coord_t             trail_y[TRAIL_DEPTH];
    int                 trail_fill;
    move_res_t          pending_moves[$];
    int                 errors;

    function new();
      stag_limit   = LIM_RST;
      wall_limit   = LIM_RST;
      mode         = MODE_SWEEP;
      sweep_right  = 1'b1;
      shift_down   = 1'b1;
      heading      = DIR_UP;
      sweep_row    = '0;
      resume_right = 1'b0;
      follow_count = 0;
      idle_count   = 0;
      last_count   = '0;
      seen_count   = 1'b0;
      trail_fill   = 0;
      errors       = 0;
    endfunction

    function void set_limit(cfg_idx_t idx, logic [LIM_W-1:0] val);
      if (idx == CFG_STAG_LIMIT)
        stag_limit = val;
      else
        wall_limit = val;
    endfunction

    static function coord_t step_x(coord_t x, dir_t d);
      if (d == DIR_LEFT) return x - 1'b1;
      if (d == DIR_RIGHT) return x + 1'b1;
      return x;
    endfunction

    static function coord_t step_y(coord_t y, dir_t d);
      if (d == DIR_UP) return y - 1'b1;
      if (d == DIR_DOWN) return y + 1'b1;
      return y;
    endfunction

    static function dir_t horiz(bit right);
      return right ? DIR_RIGHT : DIR_LEFT;
    endfunction

    static function dir_t vert(bit down);
      return down ? DIR_DOWN : DIR_UP;
    endfunction

    static function dir_t turn_cw(dir_t d);
      case (d)
        DIR_UP:   return DIR_RIGHT;
        DIR_DOWN: return DIR_LEFT;
        DIR_LEFT: return DIR_UP;
        default:  return DIR_DOWN;
      endcase
    endfunction

    static function dir_t turn_ccw(dir_t d);
      case (d)
        DIR_UP:   return DIR_LEFT;
        DIR_DOWN: return DIR_RIGHT;
        DIR_LEFT: return DIR_DOWN;
        default:  return DIR_UP;
      endcase
    endfunction

    static function dir_t reverse(dir_t d);
      case (d)
        DIR_UP:   return DIR_DOWN;
        DIR_DOWN: return DIR_UP;
        DIR_LEFT: return DIR_RIGHT;
        default:  return DIR_LEFT;
      endcase
    endfunction

    function bit visited(coord_t x, coord_t y);
      for (int i = 0; i < trail_fill; i++)
        if (trail_x[i] == x && trail_y[i] == y) return 1'b1;
      return 1'b0;
    endfunction

    // Fresh and unvisited first, then unvisited, then uncleaned, then anything free.
    function dir_t fallback_move(move_req_t r);
      for (int p = 0; p < 4; p++) begin
        for (int d = 0; d < 4; d++) begin
          dir_t dv;
          bit   recent;
          bit   clean;
          dv = dir_t'(d);
          if (r.free_m[d]) begin
            recent = visited(step_x(r.x, dv), step_y(r.y, dv));
            clean  = r.clean_m[d];
            if (p == 0 && !clean && !recent) return dv;
            if (p == 1 && !recent) return dv;
            if (p == 2 && !clean) return dv;
            if (p == 3) return dv;
          end
        end
      end
      return DIR_NONE;
    endfunction

    // Advance the planner state by one request and queue the move it yields.
    function move_res_t note_request(move_req_t r);
      move_res_t   res;
      int unsigned n;
      bit          stalled;
      bit          decided;
      bit          rejoin_ok;
      dir_t        mv;
      dir_t        cand[4];
      coord_t      ny;
      if (trail_fill < TRAIL_DEPTH) begin
        trail_x[trail_fill] = r.x;
        trail_y[trail_fill] = r.y;
        trail_fill++;
      end else begin
        for (int i = 0; i < TRAIL_DEPTH - 1; i++) begin
          trail_x[i] = trail_x[i + 1];
          trail_y[i] = trail_y[i + 1];
        end
        trail_x[TRAIL_DEPTH - 1] = r.x;
        trail_y[TRAIL_DEPTH - 1] = r.y;
      end

      if (!seen_count || r.count > last_count)
        idle_count = 0;
      else if (idle_count < CNT_MAX)
        idle_count++;
      last_count = r.count;
      seen_count = 1'b1;
      stalled    = idle_count >= stag_limit;

      mv      = DIR_NONE;
      decided = 1'b0;
      if (mode == MODE_SWEEP) begin
        if (!stalled && r.free_m[horiz(sweep_right)]) begin
          mv      = horiz(sweep_right);
          decided = 1'b1;
        end else begin
          mode = MODE_SHIFT;
        end
      end
      if (!decided && mode == MODE_SHIFT) begin
        if (!stalled && r.free_m[vert(shift_down)]) begin
          sweep_right = !sweep_right;
          mode        = MODE_SWEEP;
          mv          = vert(shift_down);
          decided     = 1'b1;
        end else if (!stalled && r.free_m[vert(!shift_down)]) begin
          shift_down  = !shift_down;
          sweep_right = !sweep_right;
          mode        = MODE_SWEEP;
          mv          = vert(shift_down);
          decided     = 1'b1;
        end else begin
          mode         = MODE_WALL;
          sweep_row    = r.y;
          resume_right = sweep_right;
          heading      = horiz(sweep_right);
          follow_count = 0;
        end
      end
      if (!decided) begin
        n            = follow_count + 1;
        follow_count = (n > CNT_MAX) ? CNT_MAX : n;
        if (n > wall_limit) begin
          mode = MODE_SWEEP;
          mv   = fallback_move(r);
        end else begin
          cand[0] = turn_cw(heading);
          cand[1] = heading;
          cand[2] = turn_ccw(heading);
          cand[3] = reverse(heading);
          for (int i = 0; i < 4; i++)
            if (mv == DIR_NONE && r.free_m[cand[i][1:0]]) mv = cand[i];
          if (mv == DIR_NONE) begin
            mode = MODE_SWEEP;
            mv   = fallback_move(r);
          end else begin
            heading   = mv;
            ny        = step_y(r.y, mv);
            rejoin_ok = resume_right ? r.rej_r[mv[1:0]] : r.rej_l[mv[1:0]];
            if (ny == sweep_row && rejoin_ok) begin
              mode        = MODE_SWEEP;
              sweep_right = resume_right;
            end
          end
        end
      end

      res.dir  = mv;
      res.mode = mode;
      pending_moves.insert(pending_moves.size(), res);
      return res;
    endfunction

    function void check_move(logic [2:0] got_dir, logic [1:0] got_mode);
      move_res_t want;
      if (pending_moves.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: move with none pending: dir %0d mode %0d", $time, got_dir, got_mode);
        return;
      end
      want = pending_moves.pop_front();
      if (got_dir !== want.dir || got_mode !== want.mode) begin
        errors++;
        if (errors <= 10)
          $display("%0t: move mismatch: dir exp %0d got %0d, mode exp %0d got %0d",
                   $time, want.dir, got_dir, want.mode, got_mode);
      end
    endfunction
  endclass

  // Settle time once the pipe is empty.
  localparam int SETTLE      = HISTORY_DEPTH_DEF + 5;
  // Cycles without any transaction before the run is stopped as failed.
  localparam int QUIET_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  coord_t             in_pos_x = '0;
  coord_t             in_pos_y = '0;
  logic [3:0]         in_free_mask = '0;
  logic [3:0]         in_cleaned_mask = '0;
  logic [3:0]         in_rejoin_left_mask = '0;
  logic [3:0]         in_rejoin_right_mask = '0;
  logic [CLEAN_W-1:0] in_cleaned_count = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_move_dir;
  logic [1:0]         out_mode_after;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = 1'b0;
  logic [LIM_W-1:0]   cfg_data = '0;

  move_board board = new();

  // Turn off random idling on both sides while set.
  bit steady = 1'b0;

  // Rover the random stimulus walks around with.
  coord_t             rover_x;
  coord_t             rover_y;
  logic [CLEAN_W-1:0] rover_count;

  int quiet_cycles = 0;

  zigzag_coverage_wall_follow_planner u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_free_mask        (in_free_mask),
    .in_cleaned_mask     (in_cleaned_mask),
    .in_rejoin_left_mask (in_rejoin_left_mask),
    .in_rejoin_right_mask(in_rejoin_right_mask),
    .in_cleaned_count    (in_cleaned_count),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_move_dir        (out_move_dir),
    .out_mode_after      (out_mode_after),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #10 clk = ~clk;

  // Stall the result side at random about 8 percent of the time, except in steady stretches.
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 8);
  end

  // Check every result transaction against the oldest pending move.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_move(out_move_dir, out_mode_after);
  end

  // Watchdog: count cycles with no transaction on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drive one request: maybe idle first, then hold it until accepted and
  // advance the scoreboard at the accepting edge.
  task automatic send_request(input move_req_t r, output move_res_t planned);
    int gap;
    gap = (!steady && $urandom_range(99) < 8) ? $urandom_range(1, 16) : 0;
    @(negedge clk);
    while (gap > 0) begin
      in_valid <= 1'b0;
      gap--;
      @(negedge clk);
    end
    in_valid             <= 1'b1;
    in_pos_x             <= r.x;
    in_pos_y             <= r.y;
    in_free_mask         <= r.free_m;
    in_cleaned_mask      <= r.clean_m;
    in_rejoin_left_mask  <= r.rej_l;
    in_rejoin_right_mask <= r.rej_r;
    in_cleaned_count     <= r.count;
    do @(posedge clk); while (in_stall);
    planned = board.note_request(r);
  endtask

  task automatic send_fields(input coord_t x, input coord_t y, input logic [3:0] free_m,
                             input logic [3:0] clean_m, input logic [3:0] rej_l,
                             input logic [3:0] rej_r, input logic [CLEAN_W-1:0] count);
    move_req_t r;
    move_res_t planned;
    r.x       = x;
    r.y       = y;
    r.free_m  = free_m;
    r.clean_m = clean_m;
    r.rej_l   = rej_l;
    r.rej_r   = rej_r;
    r.count   = count;
    send_request(r, planned);
  endtask

  // Drop valid and hold until every pending move has come back, then settle.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_moves.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input cfg_idx_t idx, input logic [LIM_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_limit(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reprogram both limits with the planner idle.
  task automatic retune(input logic [LIM_W-1:0] stag, input logic [LIM_W-1:0] wall);
    drain_results();
    write_limit(CFG_STAG_LIMIT, stag);
    write_limit(CFG_WALL_LIMIT, wall);
  endtask

  function automatic coord_t pick_coord();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return coord_t'($urandom);
  endfunction

  function automatic logic [3:0] biased_mask(input int pct);
    logic [3:0] m;
    for (int b = 0; b < 4; b++) m[b] = ($urandom_range(99) < pct);
    return m;
  endfunction

  // Walk the rover: mostly follow the planned moves so that history hits,
  // wall following and rejoins come up, with occasional jumps and edges.
  task automatic roam(input int items, input bit stagnant);
    move_req_t r;
    move_res_t planned;
    int        hold_at;
    int        roll;
    hold_at = $urandom_range(items - 1);
    for (int i = 0; i < items; i++) begin
      if (i == hold_at) drain_results();
      if ($urandom_range(99) < 5) begin
        rover_x = pick_coord();
        rover_y = pick_coord();
      end
      roll = $urandom_range(99);
      if (stagnant)
        ;
      else if (roll < 55)
        rover_count = rover_count + CLEAN_W'($urandom_range(1, 4));
      else if (roll >= 90)
        rover_count = CLEAN_W'($urandom);
      r.x  = rover_x;
      r.y  = rover_y;
      roll = $urandom_range(99);
      if (roll < 4)
        r.free_m = 4'h0;
      else if (roll < 8)
        r.free_m = 4'hF;
      else
        r.free_m = biased_mask(70);
      r.clean_m = biased_mask(40);
      r.rej_l   = biased_mask(50);
      r.rej_r   = biased_mask(50);
      r.count   = rover_count;
      send_request(r, planned);
      if (planned.dir != DIR_NONE && $urandom_range(99) < 92) begin
        rover_x = board.step_x(rover_x, planned.dir);
        rover_y = board.step_y(rover_y, planned.dir);
      end
    end
  endtask

  initial begin
    rover_x     = 8'd40;
    rover_y     = 8'd40;
    rover_count = 16'd100;

    // Hold reset low, then release it for good.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: first step counts as progress, sweep right from the origin.
    send_fields(8'd0,   8'd0,   4'hF,    4'h0, 4'h0, 4'h0, 16'h0000);
    // Boxed in at the far corner with all masks set: no move, back to sweep.
    send_fields(8'd255, 8'd255, 4'h0,    4'hF, 4'hF, 4'hF, 16'hFFFF);
    // Right step off the edge wraps the neighbor column.
    send_fields(8'd255, 8'd0,   4'b1000, 4'h0, 4'h0, 4'h0, 16'hFFFF);
    // Shift down and reverse the sweep.
    send_fields(8'd0,   8'd255, 4'b0010, 4'h0, 4'h0, 4'h0, 16'hFFFF);
    // Preferred shift blocked: take the other vertical and flip shift direction.
    send_fields(8'd1,   8'd0,   4'b0001, 4'h0, 4'h0, 4'h0, 16'd5);
    // Only left is free against a right sweep: wall follow, step left across the wrap.
    send_fields(8'd0,   8'd0,   4'b0100, 4'h0, 4'h0, 4'h0, 16'd6);
    // Still in wall follow with only the back step free: turn around.
    send_fields(8'd128, 8'd128, 4'b1000, 4'h0, 4'h0, 4'h0, 16'd7);
    send_fields(8'd129, 8'd128, 4'b0001, 4'h0, 4'h0, 4'h0, 16'd8);
    // Step down with only a left exit set: the step misses the sweep row, so wall follow goes on.
    send_fields(8'd129, 8'd127, 4'b0010, 4'h0, 4'b0010, 4'h0, 16'd9);
    send_fields(8'd129, 8'd128, 4'b0100, 4'h0, 4'h0, 4'h0, 16'd10);

    // Zero stagnation limit: every step stalls; the first exceeds the
    // one-step budget and falls back, the second enters wall follow.
    retune(13'd0, 13'd1);
    send_fields(8'd5, 8'd5, 4'hF,    4'h0,    4'h0, 4'h0, 16'd11);
    send_fields(8'd5, 8'd4, 4'b0011, 4'b0001, 4'h0, 4'h0, 16'd12);

    // Zero wall-follow budget: every stalled step goes through the fallback
    // passes (recent only, recent and clean, fresh).
    retune(13'd0, 13'd0);
    send_fields(8'd5, 8'd4, 4'b0010, 4'h0,    4'h0, 4'h0, 16'd12);
    send_fields(8'd5, 8'd5, 4'b0001, 4'b0001, 4'h0, 4'h0, 16'd12);
    send_fields(8'd5, 8'd5, 4'b1100, 4'b1000, 4'h0, 4'h0, 16'd12);
    send_fields(8'd5, 8'd5, 4'h0,    4'h0,    4'h0, 4'h0, 16'd12);

    // Random phases over several limit settings, zero and large values included.
    retune(13'd3, 13'd6);
    roam(120, 1'b0);
    retune(13'd0, 13'd4096);
    roam(120, 1'b0);
    retune(13'd4096, 13'd0);
    roam(120, 1'b0);
    // Long stretch with no idling on either side.
    retune(13'd1, 13'd2);
    steady = 1'b1;
    roam(160, 1'b0);
    steady = 1'b0;
    retune(13'd12, 13'd40);
    roam(160, 1'b0);
    retune(13'd2, 13'd1);
    roam(80, 1'b0);

    // No progress at all: the idle count climbs past the stagnation limit
    // and forces wall following and fallback moves.
    retune(13'd16, 13'd24);
    roam(60, 1'b1);

    drain_results();
    if (board.errors == 0 && board.pending_moves.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
src/zcwf_pkg.sv
src/zcwf_hist.sv
src/zcwf_plan.sv
src/zigzag_coverage_wall_follow_planner.sv
sim/tb_top.sv
